// ===== rtl/fvp_pkg.sv =====
package fvp_pkg;

  localparam int WINDOW = 5;
  localparam int RANK_W = $clog2(WINDOW);
  localparam logic [RANK_W-1:0] MED_RANK = RANK_W'(WINDOW / 2);

  localparam logic [2:0] REG_LOOP_MODE      = 3'd0;
  localparam logic [2:0] REG_TARGET_SPEED   = 3'd1;
  localparam logic [2:0] REG_GAIN_P         = 3'd2;
  localparam logic [2:0] REG_GAIN_I         = 3'd3;
  localparam logic [2:0] REG_GAIN_D         = 3'd4;
  localparam logic [2:0] REG_FEED_GAIN      = 3'd5;
  localparam logic [2:0] REG_FEED_OFFSET    = 3'd6;
  localparam logic [2:0] REG_BANG_THRESHOLD = 3'd7;

  localparam logic MODE_FEEDFWD = 1'b0;
  localparam logic MODE_INCR    = 1'b1;

  // Magnitudes at or above three times 2^23 saturate the speed after division by three.
  localparam logic [39:0] SPEED_SAT_MAG = 40'd25165824;
  // Reciprocal of three scaled by 2^27, rounded up.
  localparam logic [25:0] RECIP3 = 26'd44739243;

  localparam logic signed [23:0] SPEED_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] SPEED_MIN = 24'sh800000;
  localparam logic signed [31:0] SUM_MAX   = 32'sh7FFFFFFF;
  localparam logic signed [31:0] SUM_MIN   = 32'sh80000000;

  localparam logic signed [43:0] VOLT_MAX  = 44'sd12000;
  localparam logic signed [43:0] VOLT_MIN  = -44'sd12000;
  localparam logic signed [14:0] DRIVE_FULL = 15'sd12000;

  typedef struct packed {
    logic        loop_mode;
    logic [12:0] target_speed;
    logic [7:0]  gain_p;
    logic [7:0]  gain_i;
    logic [7:0]  gain_d;
    logic [15:0] feed_gain;
    logic [13:0] feed_offset;
    logic [15:0] bang_threshold;
  } cfg_t;

  typedef struct packed {
    logic signed [23:0] speed;
    logic signed [24:0] err;
  } speed_beat_t;

  typedef struct packed {
    logic signed [42:0] pid;
    logic signed [23:0] speed;
    logic signed [24:0] err;
  } pid_beat_t;

endpackage

// ===== rtl/fvp_filter.sv =====
module fvp_filter (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               enc_valid,
  input  logic signed [31:0] encoder_reading,
  output logic signed [31:0] filt,
  output logic               filt_valid
);

  logic signed [31:0]             window [fvp_pkg::WINDOW];
  logic                           win_valid;
  logic [fvp_pkg::RANK_W-1:0]     rank [fvp_pkg::WINDOW];
  logic signed [31:0]             median;

  // Each entry's rank counts smaller entries, with ties broken by position.
  always_comb begin
    median = '0;
    for (int i = 0; i < fvp_pkg::WINDOW; i++) begin
      rank[i] = '0;
      for (int j = 0; j < fvp_pkg::WINDOW; j++) begin
        if (j != i) begin
          if ((window[j] < window[i]) || ((window[j] == window[i]) && (j < i))) begin
            rank[i] = rank[i] + fvp_pkg::RANK_W'(1);
          end
        end
      end
      if (rank[i] == fvp_pkg::MED_RANK) begin
        median = window[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < fvp_pkg::WINDOW; k++) begin
        window[k] <= '0;
      end
      win_valid  <= 1'b0;
      filt_valid <= 1'b0;
    end else if (adv) begin
      win_valid  <= enc_valid;
      filt_valid <= win_valid;
      if (enc_valid) begin
        for (int k = 0; k < fvp_pkg::WINDOW - 1; k++) begin
          window[k] <= window[k+1];
        end
        window[fvp_pkg::WINDOW-1] <= encoder_reading;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      filt <= -median;
    end
  end

endmodule

// ===== rtl/fvp_speed.sv =====
module fvp_speed (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  fvp_pkg::cfg_t        cfg,
  input  logic signed [31:0]   filt,
  input  logic                 filt_valid,
  output fvp_pkg::speed_beat_t sb,
  output logic                 sb_valid
);

  logic signed [31:0] last_filtered;
  logic signed [32:0] diff;
  logic signed [39:0] dx;
  logic signed [39:0] scaled;
  logic signed [39:0] prod;
  logic               prod_valid;
  logic [39:0]        mag;
  logic [50:0]        qprod;
  logic [23:0]        quot;
  logic               sat;
  logic               neg;
  logic               quot_valid;
  logic signed [23:0] quot_s;
  logic signed [23:0] speed_c;
  logic signed [24:0] err_c;

  assign diff = {filt[31], filt} - {last_filtered[31], last_filtered};
  assign dx   = {{7{diff[32]}}, diff};

  always_comb begin
    if (cfg.loop_mode == fvp_pkg::MODE_FEEDFWD) begin
      scaled = (dx <<< 5) + (dx <<< 4) + (dx <<< 1);
    end else begin
      scaled = (dx <<< 7) - (dx <<< 2) + dx;
    end
  end

  assign mag   = prod[39] ? 40'(-prod) : 40'(prod);
  assign qprod = mag[24:0] * fvp_pkg::RECIP3;

  assign quot_s = $signed(quot);

  always_comb begin
    if (sat) begin
      speed_c = neg ? fvp_pkg::SPEED_MIN : fvp_pkg::SPEED_MAX;
    end else begin
      speed_c = neg ? -quot_s : quot_s;
    end
    err_c = $signed({12'b0, cfg.target_speed}) - $signed({speed_c[23], speed_c});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_filtered <= '0;
      prod_valid    <= 1'b0;
      quot_valid    <= 1'b0;
      sb_valid      <= 1'b0;
    end else if (adv) begin
      prod_valid <= filt_valid;
      quot_valid <= prod_valid;
      sb_valid   <= quot_valid;
      if (filt_valid) begin
        last_filtered <= filt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod     <= scaled;
      neg      <= prod[39];
      sat      <= (mag >= fvp_pkg::SPEED_SAT_MAG);
      quot     <= qprod[50:27];
      sb.speed <= speed_c;
      sb.err   <= err_c;
    end
  end

endmodule

// ===== rtl/fvp_pid.sv =====
module fvp_pid (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  fvp_pkg::cfg_t        cfg,
  input  fvp_pkg::speed_beat_t sb,
  input  logic                 sb_valid,
  output fvp_pkg::pid_beat_t   pb,
  output logic                 pb_valid
);

  logic signed [31:0] error_sum;
  logic signed [24:0] last_error;
  logic signed [32:0] sum_wide;
  logic signed [31:0] sum_next;
  logic signed [25:0] deriv_c;
  logic signed [25:0] deriv;
  logic signed [23:0] speed5;
  logic               sum_valid;
  logic signed [8:0]  gp_s;
  logic signed [8:0]  gi_s;
  logic signed [8:0]  gd_s;
  logic signed [33:0] pterm;
  logic signed [34:0] dterm;
  logic signed [40:0] iterm;
  logic signed [23:0] speed6;
  logic signed [24:0] err6;
  logic               term_valid;

  assign sum_wide = {error_sum[31], error_sum} + {{8{sb.err[24]}}, sb.err};
  assign deriv_c  = {sb.err[24], sb.err} - {last_error[24], last_error};

  always_comb begin
    if (sb.err == '0) begin
      sum_next = '0;
    end else if (sum_wide > $signed({fvp_pkg::SUM_MAX[31], fvp_pkg::SUM_MAX})) begin
      sum_next = fvp_pkg::SUM_MAX;
    end else if (sum_wide < $signed({fvp_pkg::SUM_MIN[31], fvp_pkg::SUM_MIN})) begin
      sum_next = fvp_pkg::SUM_MIN;
    end else begin
      sum_next = sum_wide[31:0];
    end
  end

  assign gp_s  = $signed({1'b0, cfg.gain_p});
  assign gi_s  = $signed({1'b0, cfg.gain_i});
  assign gd_s  = $signed({1'b0, cfg.gain_d});
  assign pterm = gp_s * last_error;
  assign dterm = gd_s * deriv;
  assign iterm = gi_s * error_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum  <= '0;
      last_error <= '0;
      sum_valid  <= 1'b0;
      term_valid <= 1'b0;
      pb_valid   <= 1'b0;
    end else if (adv) begin
      sum_valid  <= sb_valid;
      term_valid <= sum_valid;
      pb_valid   <= term_valid;
      if (sb_valid) begin
        error_sum  <= sum_next;
        last_error <= sb.err;
      end
    end
  end

  logic signed [33:0] pterm_r;
  logic signed [34:0] dterm_r;
  logic signed [40:0] iterm_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      deriv    <= deriv_c;
      speed5   <= sb.speed;
      pterm_r  <= pterm;
      dterm_r  <= dterm;
      iterm_r  <= iterm;
      speed6   <= speed5;
      err6     <= last_error;
      pb.pid   <= {{9{pterm_r[33]}}, pterm_r} + {{8{dterm_r[34]}}, dterm_r}
                  + {{2{iterm_r[40]}}, iterm_r};
      pb.speed <= speed6;
      pb.err   <= err6;
    end
  end

endmodule

// ===== rtl/fvp_drive.sv =====
module fvp_drive (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  fvp_pkg::cfg_t      cfg,
  input  fvp_pkg::pid_beat_t pb,
  input  logic               pb_valid,
  output logic signed [14:0] drive_mv,
  output logic signed [23:0] speed_estimate,
  output logic signed [24:0] speed_error,
  output logic               full_power,
  output logic               cmd_valid
);

  logic [28:0]        ff_prod;
  logic [13:0]        voltage_accum;
  logic signed [43:0] t_sum;
  logic signed [43:0] t_adj;
  logic signed [43:0] v_sum;
  logic [13:0]        v_next;
  logic signed [14:0] drive_c;
  logic               bang;

  // The feedforward product is split at bit 12 and the offset and PID term are
  // added as whole units, so the division by 4096 toward zero needs only a remainder test.
  assign t_sum = {pb.pid[42], pb.pid} + $signed({30'b0, cfg.feed_offset})
                 + $signed({27'b0, ff_prod[28:12]});
  assign t_adj = ((t_sum < 0) && (ff_prod[11:0] != '0)) ? t_sum + 44'sd1 : t_sum;
  assign v_sum = {pb.pid[42], pb.pid} + $signed({30'b0, voltage_accum});
  assign bang  = (pb.err >= $signed({9'b0, cfg.bang_threshold}));

  always_comb begin
    if (v_sum < 0) begin
      v_next = '0;
    end else if (v_sum > fvp_pkg::VOLT_MAX) begin
      v_next = 14'(fvp_pkg::VOLT_MAX);
    end else begin
      v_next = v_sum[13:0];
    end

    if (cfg.loop_mode == fvp_pkg::MODE_INCR) begin
      drive_c = -$signed({1'b0, v_next});
    end else if (bang) begin
      drive_c = fvp_pkg::DRIVE_FULL;
    end else if (t_adj > fvp_pkg::VOLT_MAX) begin
      drive_c = 15'(fvp_pkg::VOLT_MAX);
    end else if (t_adj < fvp_pkg::VOLT_MIN) begin
      drive_c = 15'(fvp_pkg::VOLT_MIN);
    end else begin
      drive_c = t_adj[14:0];
    end
  end

  always_ff @(posedge clk) begin
    ff_prod <= cfg.feed_gain * cfg.target_speed;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      voltage_accum <= '0;
      cmd_valid     <= 1'b0;
    end else if (adv) begin
      cmd_valid <= pb_valid;
      if (pb_valid && (cfg.loop_mode == fvp_pkg::MODE_INCR)) begin
        voltage_accum <= v_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      drive_mv       <= drive_c;
      speed_estimate <= pb.speed;
      speed_error    <= pb.err;
      full_power     <= (cfg.loop_mode == fvp_pkg::MODE_FEEDFWD) && bang;
    end
  end

endmodule

// ===== rtl/flywheel_velocity_pid_unit.sv =====
// Flywheel velocity controller. One encoder reading enters per beat on the
// enc channel (enc_valid, enc_stall, encoder_reading); one motor command
// leaves per beat on the cmd channel (cmd_valid, cmd_stall, drive_mv,
// speed_estimate, speed_error, full_power).
// The block is a nine-stage pipeline: median filter, difference and scaling,
// division by three, speed and error, integral, gain products, PID sum and
// drive selection. A reading accepted into the window passes in turn through
// every stage register to the cmd channel, and a new one is taken every cycle
// unless cmd_stall holds the pipeline, so the sustained rate is one beat per cycle.
// The whole pipeline moves together: while cmd_valid is high and cmd_stall
// is high, every stage holds, enc_stall is raised and the waiting command
// stays on the outputs unchanged.
// Configuration registers are written through cfg_write, cfg_index and
// cfg_data, and are meant to change only while no reading is in flight.
// Synchronous reset clears the median window, the filter, integral,
// derivative and voltage history, empties the pipeline and loads the
// default gains, target and mode.
module flywheel_velocity_pid_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               enc_valid,
  output logic               enc_stall,
  input  logic signed [31:0] encoder_reading,
  output logic               cmd_valid,
  input  logic               cmd_stall,
  output logic signed [14:0] drive_mv,
  output logic signed [23:0] speed_estimate,
  output logic signed [24:0] speed_error,
  output logic               full_power,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  fvp_pkg::cfg_t        cfg;
  fvp_pkg::speed_beat_t sb;
  fvp_pkg::pid_beat_t   pb;
  logic                 adv;
  logic signed [31:0]   filt;
  logic                 filt_valid;
  logic                 sb_valid;
  logic                 pb_valid;

  assign adv       = !cmd_valid || !cmd_stall;
  assign enc_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.loop_mode      <= fvp_pkg::MODE_FEEDFWD;
      cfg.target_speed   <= 13'd2250;
      cfg.gain_p         <= 8'd20;
      cfg.gain_i         <= 8'd5;
      cfg.gain_d         <= 8'd0;
      cfg.feed_gain      <= 16'd15703;
      cfg.feed_offset    <= 14'd1300;
      cfg.bang_threshold <= 16'd100;
    end else if (cfg_write) begin
      unique case (cfg_index)
        fvp_pkg::REG_LOOP_MODE:      cfg.loop_mode      <= cfg_data[0];
        fvp_pkg::REG_TARGET_SPEED:   cfg.target_speed   <= cfg_data[12:0];
        fvp_pkg::REG_GAIN_P:         cfg.gain_p         <= cfg_data[7:0];
        fvp_pkg::REG_GAIN_I:         cfg.gain_i         <= cfg_data[7:0];
        fvp_pkg::REG_GAIN_D:         cfg.gain_d         <= cfg_data[7:0];
        fvp_pkg::REG_FEED_GAIN:      cfg.feed_gain      <= cfg_data;
        fvp_pkg::REG_FEED_OFFSET:    cfg.feed_offset    <= cfg_data[13:0];
        fvp_pkg::REG_BANG_THRESHOLD: cfg.bang_threshold <= cfg_data;
      endcase
    end
  end

  fvp_filter u_filter (
    .clk             (clk),
    .rst             (rst),
    .adv             (adv),
    .enc_valid       (enc_valid),
    .encoder_reading (encoder_reading),
    .filt            (filt),
    .filt_valid      (filt_valid)
  );

  fvp_speed u_speed (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .cfg        (cfg),
    .filt       (filt),
    .filt_valid (filt_valid),
    .sb         (sb),
    .sb_valid   (sb_valid)
  );

  fvp_pid u_pid (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .cfg      (cfg),
    .sb       (sb),
    .sb_valid (sb_valid),
    .pb       (pb),
    .pb_valid (pb_valid)
  );

  fvp_drive u_drive (
    .clk            (clk),
    .rst            (rst),
    .adv            (adv),
    .cfg            (cfg),
    .pb             (pb),
    .pb_valid       (pb_valid),
    .drive_mv       (drive_mv),
    .speed_estimate (speed_estimate),
    .speed_error    (speed_error),
    .full_power     (full_power),
    .cmd_valid      (cmd_valid)
  );

endmodule

// ===== bench/flywheel_velocity_pid_unit_tb.sv =====
`timescale 1ns / 1ps
module flywheel_velocity_pid_unit_tb;

  typedef struct {
    logic signed [14:0] drive;
    logic signed [23:0] speed;
    logic signed [24:0] err;
    logic               full;
  } cmd_t;

  class pid_tracker;
    fvp_pkg::cfg_t cfg;
    int     window[fvp_pkg::WINDOW];
    int     last_filt;
    longint err_sum;
    longint last_err;
    longint volt;
    cmd_t   pending[$];
    int     fails;
    int     shown;
    int     beats;
    int     bang_count;
    int     zero_err_count;
    int     incr_count;

    function new();
      cfg = '{loop_mode: fvp_pkg::MODE_FEEDFWD, target_speed: 13'd2250, gain_p: 8'd20,
              gain_i: 8'd5, gain_d: 8'd0, feed_gain: 16'd15703, feed_offset: 14'd1300,
              bang_threshold: 16'd100};
      foreach (window[k]) window[k] = 0;
      last_filt = 0;
      err_sum = 0;
      last_err = 0;
      volt = 0;
      fails = 0;
      shown = 0;
      beats = 0;
      bang_count = 0;
      zero_err_count = 0;
      incr_count = 0;
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function void write_reg(logic [2:0] index, logic [15:0] data);
      case (index)
        fvp_pkg::REG_LOOP_MODE:      cfg.loop_mode = data[0];
        fvp_pkg::REG_TARGET_SPEED:   cfg.target_speed = data[12:0];
        fvp_pkg::REG_GAIN_P:         cfg.gain_p = data[7:0];
        fvp_pkg::REG_GAIN_I:         cfg.gain_i = data[7:0];
        fvp_pkg::REG_GAIN_D:         cfg.gain_d = data[7:0];
        fvp_pkg::REG_FEED_GAIN:      cfg.feed_gain = data;
        fvp_pkg::REG_FEED_OFFSET:    cfg.feed_offset = data[13:0];
        fvp_pkg::REG_BANG_THRESHOLD: cfg.bang_threshold = data;
        default: ;
      endcase
    endfunction

    function void take_reading(logic signed [31:0] reading);
      int     sorted[fvp_pkg::WINDOW];
      int     filt;
      int     t;
      int     a;
      int     b;
      longint diff;
      longint speed;
      longint err;
      longint sum;
      longint deriv;
      longint pid;
      longint q;
      longint drive;
      cmd_t   c;
      for (a = 0; a < fvp_pkg::WINDOW - 1; a++) window[a] = window[a + 1];
      window[fvp_pkg::WINDOW - 1] = reading;
      sorted = window;
      for (a = 1; a < fvp_pkg::WINDOW; a++) begin
        t = sorted[a];
        b = a - 1;
        while (b >= 0 && sorted[b] > t) begin
          sorted[b + 1] = sorted[b];
          b--;
        end
        sorted[b + 1] = t;
      end
      filt = -sorted[fvp_pkg::WINDOW / 2];
      diff = longint'(filt) - longint'(last_filt);
      if (cfg.loop_mode == fvp_pkg::MODE_FEEDFWD) speed = (diff * 50) / 3;
      else speed = (diff * 125) / 3;
      speed = clamp(speed, longint'(fvp_pkg::SPEED_MIN), longint'(fvp_pkg::SPEED_MAX));
      err = longint'(cfg.target_speed) - speed;
      sum = clamp(err_sum + err, longint'(fvp_pkg::SUM_MIN), longint'(fvp_pkg::SUM_MAX));
      if (err == 0) begin
        sum = 0;
        zero_err_count++;
      end
      err_sum = sum;
      deriv = err - last_err;
      last_err = err;
      pid = longint'(cfg.gain_p) * err + longint'(cfg.gain_d) * deriv
            + longint'(cfg.gain_i) * sum;
      c.full = 1'b0;
      if (cfg.loop_mode == fvp_pkg::MODE_FEEDFWD) begin
        if (err >= longint'(cfg.bang_threshold)) begin
          drive = 12000;
          c.full = 1'b1;
          bang_count++;
        end else begin
          q = longint'(cfg.feed_offset) * 4096
              + longint'(cfg.feed_gain) * longint'(cfg.target_speed) + pid * 4096;
          drive = clamp(q / 4096, -12000, 12000);
        end
      end else begin
        volt = clamp(volt + pid, 0, 12000);
        drive = -volt;
        incr_count++;
      end
      last_filt = filt;
      c.drive = drive[14:0];
      c.speed = speed[23:0];
      c.err = err[24:0];
      pending.push_back(c);
    endfunction

    function void report(string what, longint want, longint got);
      fails++;
      if (shown < 60) begin
        $display("%0t: %s expected %0d, actual %0d", $time, what, want, got);
        shown++;
      end
    endfunction

    function void check_cmd(logic signed [14:0] drive, logic signed [23:0] speed,
                            logic signed [24:0] err, logic full);
      cmd_t c;
      beats++;
      if (pending.size() == 0) begin
        fails++;
        if (shown < 60) begin
          $display("%0t: command beat with none expected, actual drive %0d speed %0d error %0d",
                   $time, drive, speed, err);
          shown++;
        end
        return;
      end
      c = pending.pop_front();
      if (drive !== c.drive) report("drive_mv", c.drive, drive);
      if (speed !== c.speed) report("speed_estimate", c.speed, speed);
      if (err !== c.err) report("speed_error", c.err, err);
      if (full !== c.full) report("full_power", c.full, full);
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               enc_valid;
  logic               enc_stall;
  logic signed [31:0] encoder_reading;
  logic               cmd_valid;
  logic               cmd_stall;
  logic signed [14:0] drive_mv;
  logic signed [23:0] speed_estimate;
  logic signed [24:0] speed_error;
  logic               full_power;
  logic               cfg_write;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_data;

  pid_tracker tracker;
  bit         tx_gaps;
  bit         rx_gaps;
  bit         squeeze_req;
  int         sent;
  int         pos;

  flywheel_velocity_pid_unit u_dut (
    .clk             (clk),
    .rst             (rst),
    .enc_valid       (enc_valid),
    .enc_stall       (enc_stall),
    .encoder_reading (encoder_reading),
    .cmd_valid       (cmd_valid),
    .cmd_stall       (cmd_stall),
    .drive_mv        (drive_mv),
    .speed_estimate  (speed_estimate),
    .speed_error     (speed_error),
    .full_power      (full_power),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("Mismatches found");
    $finish;
  end

  // The receiver stalls in bursts, or for one long stretch when asked, so the
  // pipeline fills and pushes back on the encoder side.
  initial begin
    cmd_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze_req) begin
        cmd_stall = 1'b1;
        repeat (80) @(negedge clk);
        cmd_stall = 1'b0;
        squeeze_req = 1'b0;
      end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
        cmd_stall = 1'b1;
        repeat ($urandom_range(1, 18)) @(negedge clk);
        cmd_stall = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && cmd_valid === 1'b1 && !cmd_stall)
      tracker.check_cmd(drive_mv, speed_estimate, speed_error, full_power);
  end

  task automatic send_reading(input logic signed [31:0] value);
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      enc_valid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    enc_valid = 1'b1;
    encoder_reading = value;
    do @(posedge clk); while (enc_stall);
    tracker.take_reading(value);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    enc_valid = 1'b0;
    while (tracker.pending.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] index, input logic [15:0] data);
    cfg_write = 1'b1;
    cfg_index = index;
    cfg_data = data;
    tracker.write_reg(index, data);
    @(negedge clk);
  endtask

  task automatic load_settings(input logic mode, input logic [12:0] target,
                               input logic [7:0] gp, input logic [7:0] gi,
                               input logic [7:0] gd, input logic [15:0] fg,
                               input logic [13:0] fo, input logic [15:0] th);
    write_reg(fvp_pkg::REG_LOOP_MODE, mode);
    write_reg(fvp_pkg::REG_TARGET_SPEED, target);
    write_reg(fvp_pkg::REG_GAIN_P, gp);
    write_reg(fvp_pkg::REG_GAIN_I, gi);
    write_reg(fvp_pkg::REG_GAIN_D, gd);
    write_reg(fvp_pkg::REG_FEED_GAIN, fg);
    write_reg(fvp_pkg::REG_FEED_OFFSET, fo);
    write_reg(fvp_pkg::REG_BANG_THRESHOLD, th);
    cfg_write = 1'b0;
  endtask

  // Runs of rotation at varied speeds, many near the target, with outliers the median
  // should reject, bursts of raw noise and near-stationary dithering.
  task automatic run_phase(input int count);
    int left;
    int len;
    int nominal;
    int step;
    int kind;
    int k;
    left = count;
    if (tracker.cfg.loop_mode == fvp_pkg::MODE_FEEDFWD)
      nominal = tracker.cfg.target_speed * 3 / 50;
    else nominal = tracker.cfg.target_speed * 3 / 125;
    while (left > 0) begin
      kind = $urandom_range(0, 19);
      if (kind < 14) begin
        len = $urandom_range(5, 20);
        case ($urandom_range(0, 3))
          0: step = nominal;
          1: step = nominal + $urandom_range(0, 6) - 3;
          2: step = $urandom_range(0, 2 * nominal + 4);
          default: step = $urandom_range(0, 3000000) - 1500000;
        endcase
        for (k = 0; k < len && left > 0; k++) begin
          pos -= step;
          if ($urandom_range(0, 11) == 0) send_reading($urandom);
          else send_reading(pos);
          left--;
        end
      end else if (kind < 17) begin
        len = $urandom_range(1, 4);
        for (k = 0; k < len && left > 0; k++) begin
          send_reading($urandom);
          left--;
        end
      end else begin
        len = $urandom_range(3, 8);
        for (k = 0; k < len && left > 0; k++) begin
          send_reading(pos + $urandom_range(0, 8) - 4);
          left--;
        end
      end
    end
  endtask

  initial begin
    int ph;
    int k;
    rst = 1'b1;
    enc_valid = 1'b0;
    encoder_reading = '0;
    cfg_write = 1'b0;
    cfg_index = fvp_pkg::REG_LOOP_MODE;
    cfg_data = '0;
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    squeeze_req = 1'b0;
    sent = 0;
    pos = 0;
    tracker = new();
    repeat (5) @(negedge clk);
    rst = 1'b0;

    send_reading(32'sh7FFFFFFF);
    repeat (3) send_reading(32'sh80000000);
    send_reading(-32'sd1);
    send_reading(32'sd1);
    repeat (3) send_reading(32'sh7FFFFFFF);
    for (k = 0; k < 12; k++) begin
      pos -= 135;
      if (k == 6) send_reading(32'sh7FFFFFFF);
      else send_reading(pos);
    end
    drain();
    write_reg(fvp_pkg::REG_LOOP_MODE, fvp_pkg::MODE_INCR);
    cfg_write = 1'b0;
    for (k = 0; k < 5; k++) begin
      pos -= 54;
      send_reading(pos);
    end
    drain();

    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    for (ph = 0; ph < 11; ph++) begin
      case (ph)
        0: load_settings(fvp_pkg::MODE_FEEDFWD, 0, 0, 0, 0, 0, 0, 0);
        1: load_settings(fvp_pkg::MODE_INCR, 6000, 255, 255, 255, 16'hFFFF, 12000,
                         16'hFFFF);
        2: load_settings(fvp_pkg::MODE_FEEDFWD, 13'h1FFF, 255, 0, 255, 16'hFFFF,
                         14'h3FFF, 16'hFFFF);
        4: load_settings(fvp_pkg::MODE_FEEDFWD, $urandom_range(0, 6000), 1, 1, 0, 15703,
                         1300, 16'hFFFF);
        default: load_settings($urandom_range(0, 1), $urandom_range(0, 6000),
                               ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                           : $urandom_range(0, 30),
                               ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                           : $urandom_range(0, 10),
                               ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                           : $urandom_range(0, 10),
                               ($urandom_range(0, 1) == 0) ? $urandom_range(0, 65535)
                                                           : $urandom_range(14000, 17000),
                               $urandom_range(0, 12000),
                               ($urandom_range(0, 2) == 0) ? $urandom_range(0, 65535)
                                                           : $urandom_range(0, 300));
      endcase
      if (ph == 3 || ph == 8) squeeze_req = 1'b1;
      if (ph == 10) begin
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
      end
      if (ph == 4) begin
        // A fast spin pins the speed at its negative limit long enough for
        // the error integral to reach its ceiling.
        for (k = 0; k < 270; k++) begin
          pos += 1000000 + $urandom_range(0, 999);
          send_reading(pos);
        end
      end else begin
        run_phase(55);
      end
      drain();
    end

    $display("Sent %0d encoder readings over 11 setting phases; %0d command beats checked.",
             sent, tracker.beats);
    $display("Saw %0d full-power steps, %0d zero-error steps, %0d incremental-mode steps.",
             tracker.bang_count, tracker.zero_err_count, tracker.incr_count);
    if (tracker.fails == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
